@@ rtl/cglm_pkg.sv @@
// ----------------------------------------------------------------------------
// cglm_pkg
// Shared constants and helpers for the context gated logistic mixer.
// ----------------------------------------------------------------------------
package cglm_pkg;

   localparam int LANES_DEF        = 8;
   localparam int CONTEXT_ROWS_DEF = 256;
   localparam int EXTRA_LANES_DEF  = 2;
   localparam int FIELD_LANES      = 8;

   localparam logic [24:0] STEP_LIMIT_A = 25'd1000000;
   localparam logic [24:0] STEP_LIMIT_B = 25'd5000000;
   localparam logic [24:0] STEP_LIMIT_C = 25'd25000000;

   localparam logic [16:0] DECAY_ONE = 17'd65536;
   localparam logic [16:0] DECAY_A   = 17'd45875;
   localparam logic [16:0] DECAY_B   = 17'd19661;
   localparam logic [16:0] DECAY_C   = 17'd13107;

   localparam logic [13:0] SHRINK_Q32 = 14'd12885;
   localparam logic [15:0] RATE_RESET = 16'd131;

   localparam logic OP_MIX   = 1'b0;
   localparam logic OP_LEARN = 1'b1;

   typedef struct packed {
      logic        start;
      logic        learn;
      logic        shrink;
      logic [24:0] unused_pad;
   } lane_ctl_type;

   // logistic(k/2) in Q0.16
   function automatic logic [16:0] sig_entry(input logic [4:0] k);
      logic [16:0] v;
      begin
         case (k)
            5'd0: v = 17'd32768;
            5'd1: v = 17'd40793;
            5'd2: v = 17'd47911;
            5'd3: v = 17'd53581;
            5'd4: v = 17'd57724;
            5'd5: v = 17'd60565;
            5'd6: v = 17'd62428;
            5'd7: v = 17'd63615;
            5'd8: v = 17'd64357;
            5'd9: v = 17'd64816;
            5'd10: v = 17'd65097;
            5'd11: v = 17'd65269;
            5'd12: v = 17'd65374;
            5'd13: v = 17'd65438;
            5'd14: v = 17'd65476;
            5'd15: v = 17'd65500;
            default: v = 17'd65514;
         endcase
         return v;
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      begin
         if (x > 64'sd2147483647) r = 32'sh7fffffff;
         else if (x < -64'sd2147483648) r = 32'sh80000000;
         else r = x[31:0];
         return r;
      end
   endfunction

endpackage

@@ rtl/context_gated_logistic_mixer.sv @@
// ----------------------------------------------------------------------------
// context_gated_logistic_mixer
// Context selected weight rows, dot product mix and logistic learn step.
// ----------------------------------------------------------------------------
// Usage:
//  req_ channel carries one transaction: opcode 0 mixes the inputs with the
//  row of context_index and returns mixed_logit on rsp_; opcode 1 learns from
//  observed_bit against the last mix and returns nothing.
//  csr_ channel writes the adaptation rate (Q0.16); write only while idle.
//  One transaction is in flight at a time; the lane RAM port and the update
//  chain set this. Logistic, error and decay*rate are latched on accept, the
//  update at READ, lane products at MUL, the merge or new weight at MERGE,
//  the weight write back at WRITE. A mix result passes READ, MUL and MERGE
//  after its accept; the next transaction can be accepted back in IDLE.
//  After reset a clearing pass zeroes all weight rows and step counts,
//  during which req_ready stays low.
//  A mix result sits in an output register; while the receiver stalls the
//  block holds it and takes no further transaction.
// ----------------------------------------------------------------------------
module context_gated_logistic_mixer #(
   parameter int LANES        = cglm_pkg::LANES_DEF,
   parameter int CONTEXT_ROWS = cglm_pkg::CONTEXT_ROWS_DEF,
   parameter int EXTRA_LANES  = cglm_pkg::EXTRA_LANES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [0:0]         req_opcode,
   input  logic [7:0]         req_context_index,
   input  logic signed [15:0] req_input_0,
   input  logic signed [15:0] req_input_1,
   input  logic signed [15:0] req_input_2,
   input  logic signed [15:0] req_input_3,
   input  logic signed [15:0] req_input_4,
   input  logic signed [15:0] req_input_5,
   input  logic signed [15:0] req_input_6,
   input  logic signed [15:0] req_input_7,
   input  logic [0:0]         req_observed_bit,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_mixed_logit,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_adapt_rate
);

   localparam int AW = (CONTEXT_ROWS > 1) ? $clog2(CONTEXT_ROWS) : 1;
   localparam int RD = (CONTEXT_ROWS > 1) ? CONTEXT_ROWS : 2;
   localparam int FIELD_SZ = cglm_pkg::FIELD_LANES;
   localparam int EXTRA_EFF  = (EXTRA_LANES > LANES) ? LANES : EXTRA_LANES;
   localparam int MAIN_LANES = LANES - EXTRA_EFF;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_MERGE = 3'd4;
   localparam logic [2:0] ST_WRITE = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [AW:0] clr_cnt_ff;
   logic [15:0] rate_ff;
   logic [24:0] gstep_ff;
   logic signed [15:0] held_in_ff [LANES];
   logic signed [31:0] held_logit_ff;
   logic [AW-1:0] held_ctx_ff;
   logic          op_ff;
   logic signed [31:0] update_ff;
   logic signed [33:0] err_ff;
   logic [32:0]  dr_ff;
   logic         shrink_ff;
   logic         rsp_valid_ff;
   logic signed [31:0] rsp_data_ff;
   logic signed [15:0] fld [FIELD_SZ];
   logic signed [47:0] prods [LANES];
   logic [9:0]   cnt_rd;
   cglm_pkg::lane_ctl_type ctl;

   assign fld[0] = req_input_0; assign fld[1] = req_input_1;
   assign fld[2] = req_input_2; assign fld[3] = req_input_3;
   assign fld[4] = req_input_4; assign fld[5] = req_input_5;
   assign fld[6] = req_input_6; assign fld[7] = req_input_7;

   logic req_fire;
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_cnt_ff == (AW+1)'(RD - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (req_fire) state_in = ST_READ;
         ST_READ:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_MERGE;
         ST_MERGE: state_in = ST_WRITE;
         ST_WRITE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   logic clr_en;
   assign clr_en = (state_ff == ST_CLEAR);
   logic [AW-1:0] row_addr;
   assign row_addr = clr_en ? clr_cnt_ff[AW-1:0] : held_ctx_ff;

   // context reduced to a row index, constant lookup over all 256 keys
   logic [AW-1:0] ctx_mod;
   always_comb begin
      ctx_mod = '0;
      for (int k = 0; k < 256; k++)
         if (req_context_index == 8'(k)) ctx_mod = AW'(k % CONTEXT_ROWS);
   end

   // held values latched on accept: opcode always, context and inputs for a mix only
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ctx_ff <= '0;
         for (int i = 0; i < LANES; i++) held_in_ff[i] <= '0;
         op_ff <= 1'b0;
      end else if (req_fire) begin
         op_ff  <= req_opcode[0];
         if (req_opcode[0] == cglm_pkg::OP_MIX) begin
            held_ctx_ff <= (CONTEXT_ROWS > 1) ? ctx_mod : '0;
            for (int i = 0; i < LANES; i++)
               held_in_ff[i] <= (i < FIELD_SZ) ? fld[i % FIELD_SZ] : 16'sd0;
         end
      end
   end

   // row step counters
   logic [9:0] cnt_wr;
   logic       cnt_we;
   assign cnt_wr = clr_en ? 10'd0 : cnt_rd + 10'd1;
   assign cnt_we = clr_en || (state_ff == ST_WRITE && op_ff == cglm_pkg::OP_LEARN);
   cglm_ram #(.WIDTH(10), .DEPTH(RD)) u_cnt (
      .clock(clock), .wr_en(cnt_we), .addr(row_addr), .wr_data(cnt_wr), .rd_data(cnt_rd)
   );

   // logistic of the held logit
   logic [31:0] mag;
   logic [16:0] sig_v, s0, s1, sig_s;
   logic [40:0] interp;
   assign mag = held_logit_ff[31] ? (32'd0 - held_logit_ff) : held_logit_ff;
   always_comb begin
      s0 = cglm_pkg::sig_entry(mag[27:23]);
      s1 = cglm_pkg::sig_entry(mag[27:23] + 5'd1);
      interp = 41'(s1 - s0) * 41'(mag[22:0]);
      if (mag[31:27] != 5'd0) sig_v = cglm_pkg::sig_entry(5'd16);
      else sig_v = s0 + 17'(interp >> 23);
      sig_s = held_logit_ff[31] ? (17'd65536 - sig_v) : sig_v;
   end

   // decay chosen by the global step count before it advances
   logic [16:0] decay_sel;
   always_comb begin
      if (gstep_ff < cglm_pkg::STEP_LIMIT_A) decay_sel = cglm_pkg::DECAY_ONE;
      else if (gstep_ff < cglm_pkg::STEP_LIMIT_B) decay_sel = cglm_pkg::DECAY_A;
      else if (gstep_ff < cglm_pkg::STEP_LIMIT_C) decay_sel = cglm_pkg::DECAY_B;
      else decay_sel = cglm_pkg::DECAY_C;
   end

   // learn: err and decay*rate on accept, update at READ
   logic signed [63:0] upd_full;
   assign upd_full = (64'(signed'({1'b0, dr_ff})) * 64'(err_ff) + 64'sd8388608) >>> 24;
   always_ff @(posedge clock) begin
      if (req_fire) begin
         err_ff <= 34'(signed'({1'b0, sig_s}))
                   - (req_observed_bit[0] ? 34'sd65536 : 34'sd0);
         dr_ff  <= 33'(decay_sel) * 33'(rate_ff);
      end
      if (state_ff == ST_READ) update_ff <= upd_full[31:0];
      if (state_ff == ST_MERGE) shrink_ff <= (cnt_rd == 10'd1023);
   end

   assign ctl.start = req_fire;
   assign ctl.learn = (op_ff == cglm_pkg::OP_LEARN);
   assign ctl.shrink = shrink_ff;
   assign ctl.unused_pad = '0;

   // lanes: product formed at MUL, new weight at MERGE, write back at WRITE
   genvar g;
   generate
      for (g = 0; g < LANES; g++) begin : g_lane
         cglm_lane #(.CONTEXT_ROWS(RD)) u_lane (
            .clock(clock), .reset(reset), .row_addr(row_addr), .clr_en(clr_en),
            .rd_phase(state_ff == ST_MERGE && ctl.learn),
            .mul_phase(state_ff == ST_MUL),
            .wr_phase(state_ff == ST_WRITE), .ctl(ctl),
            .lane_input(held_in_ff[g]), .update(update_ff), .product(prods[g])
         );
      end
   endgenerate

   // merge of lane products: main and extra groups, then one sum
   logic signed [63:0] main_sum, extra_sum, dot;
   always_comb begin
      main_sum  = '0;
      extra_sum = '0;
      for (int i = 0; i < LANES; i++) begin
         if (i < MAIN_LANES) main_sum = main_sum + 64'(prods[i]);
         else                extra_sum = extra_sum + 64'(prods[i]);
      end
      dot = main_sum + extra_sum;
   end

   logic signed [31:0] logit_new;
   assign logit_new = cglm_pkg::sat32((dot + 64'sd2048) >>> 12);

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= cglm_pkg::RATE_RESET;
         gstep_ff <= '0;
         held_logit_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) rate_ff <= csr_adapt_rate;
         if (state_ff == ST_WRITE && ctl.learn && gstep_ff < cglm_pkg::STEP_LIMIT_C)
            gstep_ff <= gstep_ff + 25'd1;
         if (state_ff == ST_MERGE && !ctl.learn) begin
            held_logit_ff <= logit_new;
            rsp_data_ff   <= logit_new;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_mixed_logit = rsp_data_ff;

`ifndef SYNTH
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("accept while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_mixed_logit)))
      else $error("response dropped");
   a_gstep_sat: assert property (@(posedge clock) disable iff (reset)
      gstep_ff <= cglm_pkg::STEP_LIMIT_C) else $error("step count overrun");
`endif

endmodule

@@ rtl/cglm_ram.sv @@
// ----------------------------------------------------------------------------
// cglm_ram
// Generic single port RAM with registered read.
// ----------------------------------------------------------------------------
module cglm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

@@ rtl/cglm_lane.sv @@
// ----------------------------------------------------------------------------
// cglm_lane
// One weight lane: owns its column of weights, forms the product for a mix
// and applies the update and shrink for a learn.
// ----------------------------------------------------------------------------
module cglm_lane #(
   parameter int CONTEXT_ROWS = cglm_pkg::CONTEXT_ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [$clog2(CONTEXT_ROWS)-1:0] row_addr,
   input  logic                            clr_en,
   input  logic                            rd_phase,
   input  logic                            mul_phase,
   input  logic                            wr_phase,
   input  cglm_pkg::lane_ctl_type          ctl,
   input  logic signed [15:0]              lane_input,
   input  logic signed [31:0]              update,
   output logic signed [47:0]              product
);

   logic signed [31:0] rd_w;
   logic signed [31:0] wr_w;
   logic               wen;
   logic signed [47:0] prod_ff, prod_in;
   logic signed [31:0] w1_ff, w1_in;

   assign wen = clr_en | (wr_phase & ctl.learn);

   cglm_ram #(.WIDTH(32), .DEPTH(CONTEXT_ROWS)) u_ram (
      .clock(clock), .wr_en(wen), .addr(row_addr),
      .wr_data(clr_en ? 32'd0 : wr_w), .rd_data(rd_w)
   );

   // multiply: weight by input for a mix, update by input for a learn
   always_comb begin
      prod_in = prod_ff;
      if (mul_phase) begin
         if (ctl.learn) prod_in = 48'(update) * 48'(lane_input);
         else           prod_in = 48'(rd_w) * 48'(lane_input);
      end
   end

   // weight minus rounded delta
   logic signed [63:0] wd;
   always_comb begin
      wd = 64'(rd_w) - ((64'(prod_ff) + 64'sd2048) >>> 12);
      w1_in = cglm_pkg::sat32(wd);
   end

   // shrink, one multiply after the register
   logic signed [63:0] cut;
   always_comb begin
      cut = (64'(w1_ff) * 64'(signed'({1'b0, cglm_pkg::SHRINK_Q32})) + 64'sd2147483648) >>> 32;
      wr_w = ctl.shrink ? cglm_pkg::sat32(64'(w1_ff) - cut) : w1_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (rd_phase) w1_ff <= w1_in;
   end

   assign product = prod_ff;

   logic unused;
   assign unused = reset ^ ctl.start ^ (^ctl.unused_pad);

endmodule
